// File: src/assert_macros.svh
// assertion macros shared by the dispatcher rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define APJD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define APJD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/apjd_pkg.sv
// shared types and constants of the aging priority job dispatcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apjd_pkg;

  localparam int unsigned MAX_JOBS_DEF = 64;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned JOB_IDX_W    = 7;

  // opcodes of an input word
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // status codes of a result word
  localparam logic [1:0] STAT_ADDED      = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_DISPATCHED = 2'd2;
  localparam logic [1:0] STAT_EMPTY      = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] arrival;
    logic [31:0] priority_req;
    logic [31:0] burst;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    finish_time;
  } out_t;

  // one stored job
  typedef struct packed {
    logic [31:0]          arrival;
    logic signed [32:0]   aged_pri;
    logic [31:0]          burst;
    logic [JOB_IDX_W-1:0] index;
  } entry_t;

  // incumbent status seen by the compare unit
  typedef struct packed {
    logic vld;
    logic arrived;
  } cmp_inc_t;

  // compare unit verdict
  typedef struct packed {
    logic take;
    logic arrived;
  } cmp_res_t;

endpackage

`default_nettype wire

// File: src/aging_priority_job_dispatcher.sv
// add: busy until the slot scan stops at the first free slot or finds the table full
// dispatch: busy for one ram read and one compare per table slot, then a drain and a commit
//   state; the result word of either arrives in the same cycle that busy falls
// a new word is accepted only while idle, so words are handled one at a time
// reset clears valid bits and time and sets the index counter to 1 at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aging_priority_job_dispatcher import apjd_pkg::*; #(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire in_t  item_i,
  output logic      busy_o,
  output logic      done_o,
  output out_t      result_o
);

  localparam int unsigned IdxW  = $clog2(MAX_JOBS);
  localparam int unsigned EntW  = $bits(entry_t);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [IdxW-1:0]      cnt_q, cnt_d;
  in_t                  cmd_q, cmd_d;
  logic [MAX_JOBS-1:0]  valid_q, valid_d;
  logic [TIME_W-1:0]    cur_time_q, cur_time_d;
  logic [JOB_IDX_W-1:0] next_idx_q, next_idx_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]      rd_slot_q, rd_slot_d;
  logic                 inc_vld_q, inc_vld_d;
  logic                 inc_arr_q, inc_arr_d;
  entry_t               inc_q, inc_d;
  logic [IdxW-1:0]      inc_slot_q, inc_slot_d;
  logic                 done_q, done_d;
  out_t                 result_q, result_d;

  logic                 last;
  logic                 ram_we;
  entry_t               new_entry;
  logic [EntW-1:0]      ram_rdata;
  entry_t               rd_entry;
  cmp_inc_t             inc_stat;
  cmp_res_t             cmp_res;
  logic [TIME_W-1:0]    start_time;
  logic [TIME_W:0]      fin_sum;
  logic [TIME_W-1:0]    fin_time;

  assign last = (cnt_q == IdxW'(MAX_JOBS - 1));

  // new job word built from the latched add command
  always_comb begin
    new_entry.arrival  = cmd_q.arrival;
    new_entry.aged_pri = $signed({1'b0, cmd_q.priority_req}) - $signed({1'b0, cmd_q.arrival});
    new_entry.burst    = cmd_q.burst;
    new_entry.index    = next_idx_q;
  end

  // job table
  apjd_ram #(
    .Width(EntW),
    .Depth(MAX_JOBS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q),
    .wdata_i(EntW'(new_entry)),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // shared compare unit
  assign inc_stat.vld     = inc_vld_q;
  assign inc_stat.arrived = inc_arr_q;

  apjd_cmp u_cmp (
    .cand_i    (rd_entry),
    .inc_i     (inc_q),
    .inc_stat_i(inc_stat),
    .cur_time_i(cur_time_q),
    .res_o     (cmp_res)
  );

  // finish time of the incumbent, saturating
  assign start_time = ({16'd0, inc_q.arrival} > cur_time_q) ? {16'd0, inc_q.arrival}
                                                            : cur_time_q;
  assign fin_sum  = {1'b0, start_time} + (TIME_W + 1)'(inc_q.burst);
  assign fin_time = fin_sum[TIME_W] ? {TIME_W{1'b1}} : fin_sum[TIME_W-1:0];

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    valid_d    = valid_q;
    cur_time_d = cur_time_q;
    next_idx_d = next_idx_q;
    rd_pend_d  = rd_pend_q;
    rd_slot_d  = rd_slot_q;
    inc_vld_d  = inc_vld_q;
    inc_arr_d  = inc_arr_q;
    inc_d      = inc_q;
    inc_slot_d = inc_slot_q;
    done_d     = 1'b0;
    result_d   = result_q;
    ram_we     = 1'b0;

    // fold the word read last cycle into the incumbent
    if ((state_q == S_SCAN || state_q == S_DRAIN) && rd_pend_q && cmp_res.take) begin
      inc_vld_d  = 1'b1;
      inc_arr_d  = cmp_res.arrived;
      inc_d      = rd_entry;
      inc_slot_d = rd_slot_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d     = item_i;
          cnt_d     = '0;
          rd_pend_d = 1'b0;
          inc_vld_d = 1'b0;
          state_d   = (item_i.opcode == OP_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (!valid_q[cnt_q]) begin
          ram_we               = 1'b1;
          valid_d[cnt_q]       = 1'b1;
          result_d.status      = STAT_ADDED;
          result_d.job_index   = next_idx_q;
          result_d.finish_time = '0;
          done_d               = 1'b1;
          next_idx_d           = next_idx_q + JOB_IDX_W'(1);
          state_d              = S_IDLE;
        end else if (last) begin
          result_d.status      = STAT_FULL;
          result_d.job_index   = '0;
          result_d.finish_time = '0;
          done_d               = 1'b1;
          state_d              = S_IDLE;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_SCAN: begin
        rd_pend_d = valid_q[cnt_q];
        rd_slot_d = cnt_q;
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        rd_pend_d = 1'b0;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        if (inc_vld_q) begin
          valid_d[inc_slot_q]  = 1'b0;
          cur_time_d           = fin_time;
          result_d.status      = STAT_DISPATCHED;
          result_d.job_index   = inc_q.index;
          result_d.finish_time = fin_time;
        end else begin
          result_d.status      = STAT_EMPTY;
          result_d.job_index   = '0;
          result_d.finish_time = '0;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      valid_q    <= '0;
      cur_time_q <= '0;
      next_idx_q <= JOB_IDX_W'(1);
      rd_pend_q  <= 1'b0;
      inc_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      valid_q    <= valid_d;
      cur_time_q <= cur_time_d;
      next_idx_q <= next_idx_d;
      rd_pend_q  <= rd_pend_d;
      inc_vld_q  <= inc_vld_d;
      done_q     <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_slot_q  <= rd_slot_d;
    inc_arr_q  <= inc_arr_d;
    inc_q      <= inc_d;
    inc_slot_q <= inc_slot_d;
    result_q   <= result_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // a result word always arrives with the block free again
  `APJD_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result word while still busy")
  // an accepted word always starts a busy period
  `APJD_ASSERT_NXT(a_start_busy, start_i && !busy_o, busy_o, "accepted word did not start")
  // an add fills exactly one slot
  `APJD_ASSERT_IMP(a_add_fill, done_o && (result_o.status == STAT_ADDED),
                   $countones(valid_q) == $past($countones(valid_q)) + 1,
                   "add did not fill exactly one slot")
  // a dispatch frees exactly one slot
  `APJD_ASSERT_IMP(a_dsp_free, done_o && (result_o.status == STAT_DISPATCHED),
                   $countones(valid_q) + 1 == $past($countones(valid_q)),
                   "dispatch did not free exactly one slot")

endmodule

`default_nettype wire

// File: src/apjd_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module apjd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/apjd_cmp.sv
// shared compare unit: decides whether a scanned job replaces the incumbent
// depends on apjd_pkg
`timescale 1ns / 1ps
`default_nettype none

module apjd_cmp import apjd_pkg::*; (
  input  wire entry_t              cand_i,
  input  wire entry_t              inc_i,
  input  wire cmp_inc_t            inc_stat_i,
  input  wire logic [TIME_W-1:0]   cur_time_i,
  output cmp_res_t                 res_o
);

  logic cand_arr;
  logic rank_ahead;
  logic earlier;

  // candidate has arrived by the current time
  assign cand_arr = ({16'd0, cand_i.arrival} <= cur_time_i);

  // aged priority, then shorter burst, then lower index
  always_comb begin
    if (cand_i.aged_pri != inc_i.aged_pri) begin
      rank_ahead = (cand_i.aged_pri > inc_i.aged_pri);
    end else if (cand_i.burst != inc_i.burst) begin
      rank_ahead = (cand_i.burst < inc_i.burst);
    end else begin
      rank_ahead = (cand_i.index < inc_i.index);
    end
  end

  // earliest arrival first, rank on a tie
  assign earlier = (cand_i.arrival < inc_i.arrival) ||
                   ((cand_i.arrival == inc_i.arrival) && rank_ahead);

  // arrived jobs beat pending ones; an empty incumbent is always replaced
  always_comb begin
    res_o.arrived = cand_arr;
    if (!inc_stat_i.vld) begin
      res_o.take = 1'b1;
    end else if (cand_arr && !inc_stat_i.arrived) begin
      res_o.take = 1'b1;
    end else if (cand_arr && inc_stat_i.arrived) begin
      res_o.take = rank_ahead;
    end else if (!cand_arr && !inc_stat_i.arrived) begin
      res_o.take = earlier;
    end else begin
      res_o.take = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_aging_priority_job_dispatcher.sv
// testbench of the aging priority job dispatcher: directed and random words, each result
// checked field by field against a behavioral model of the job table kept here
// depends on apjd_pkg and aging_priority_job_dispatcher
`timescale 1ns / 1ps

module tb_aging_priority_job_dispatcher;
  import apjd_pkg::*;

  localparam int unsigned JOBS        = MAX_JOBS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned WORD_TARGET = 1900;
  localparam int unsigned STEADY_FROM = 1700;
  localparam int unsigned WIDE_FROM   = 1300;
  localparam logic [31:0] WORD_MAX    = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  in_t  item_i  = '0;
  logic busy_o;
  logic done_o;
  out_t result_o;

  // model of the job table
  logic                 job_live    [JOBS];
  logic [31:0]          job_arrival [JOBS];
  logic signed [32:0]   job_aged    [JOBS];
  logic [31:0]          job_burst   [JOBS];
  logic [JOB_IDX_W-1:0] job_tag     [JOBS];
  logic [TIME_W-1:0]    sched_time;
  logic [JOB_IDX_W-1:0] next_tag;

  out_t        pending_results [$];
  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          steady_drive = 1'b0;

  aging_priority_job_dispatcher DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // slot a goes ahead of slot b: higher aged priority, shorter burst, lower index
  function automatic bit outranks(int a, int b);
    if (job_aged[a] != job_aged[b]) return job_aged[a] > job_aged[b];
    if (job_burst[a] != job_burst[b]) return job_burst[a] < job_burst[b];
    return job_tag[a] < job_tag[b];
  endfunction

  function automatic int unsigned live_jobs();
    int unsigned n;
    n = 0;
    for (int i = 0; i < JOBS; i++) n += 32'(job_live[i]);
    return n;
  endfunction

  // apply one accepted word to the table model and return its result word
  function automatic out_t schedule_word(in_t w);
    out_t              r;
    int                slot;
    int                pick;
    int                early;
    logic [TIME_W-1:0] t0;
    logic [TIME_W:0]   fin;
    r     = '0;
    slot  = -1;
    pick  = -1;
    early = -1;
    if (w.opcode == OP_ADD) begin
      // first free slot, drop the job when there is none
      for (int i = 0; i < JOBS; i++)
        if (slot < 0 && !job_live[i]) slot = i;
      if (slot < 0) begin
        r.status = STAT_FULL;
      end else begin
        job_live[slot]    = 1'b1;
        job_arrival[slot] = w.arrival;
        job_aged[slot]    = $signed({1'b0, w.priority_req}) - $signed({1'b0, w.arrival});
        job_burst[slot]   = w.burst;
        job_tag[slot]     = next_tag;
        r.status          = STAT_ADDED;
        r.job_index       = next_tag;
        next_tag          = next_tag + JOB_IDX_W'(1);
      end
    end else begin
      // best arrived job, else best among the earliest arrivals
      for (int i = 0; i < JOBS; i++) begin
        if (job_live[i]) begin
          if (job_arrival[i] <= sched_time && (pick < 0 || outranks(i, pick))) pick = i;
          if (early < 0 || job_arrival[i] < job_arrival[early] ||
              (job_arrival[i] == job_arrival[early] && outranks(i, early))) early = i;
        end
      end
      if (pick < 0) pick = early;
      if (pick < 0) begin
        r.status = STAT_EMPTY;
      end else begin
        t0 = sched_time;
        if (job_arrival[pick] > t0) t0 = TIME_W'(job_arrival[pick]);
        fin            = {1'b0, t0} + (TIME_W + 1)'(job_burst[pick]);
        sched_time     = fin[TIME_W] ? TIME_SAT : fin[TIME_W-1:0];
        job_live[pick] = 1'b0;
        r.status       = STAT_DISPATCHED;
        r.job_index    = job_tag[pick];
        r.finish_time  = sched_time;
      end
    end
    return r;
  endfunction

  // result check against the oldest expected word
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with none expected: status %0d index %0d finish %0d",
                   $realtime, result_o.status, result_o.job_index, result_o.finish_time);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status || result_o.job_index !== want.job_index ||
            result_o.finish_time !== want.finish_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected status %0d index %0d finish %0d, got %0d %0d %0d",
                     $realtime, want.status, want.job_index, want.finish_time,
                     result_o.status, result_o.job_index, result_o.finish_time);
        end
      end
    end
  end

  // send one word, with a random idle burst ahead of it outside the steady part
  task automatic send_word(input in_t w);
    if (!steady_drive && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), schedule_word(w));
    words_sent++;
  endtask

  task automatic add_job(input logic [31:0] arr, input logic [31:0] pri,
                         input logic [31:0] bst);
    in_t w;
    w.opcode       = OP_ADD;
    w.arrival      = arr;
    w.priority_req = pri;
    w.burst        = bst;
    send_word(w);
  endtask

  // dispatch word, the unused fields carry random bits
  task automatic dispatch_job();
    in_t w;
    w.opcode       = OP_DISPATCH;
    w.arrival      = $urandom;
    w.priority_req = $urandom;
    w.burst        = $urandom;
    send_word(w);
  endtask

  // arrival often near the current time so both pick paths stay alive
  function automatic logic [31:0] rand_arrival();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 7);
      3, 4, 5: return sched_time[31:0] + 32'($urandom_range(0, 48)) - 32'd24;
      6, 7:    return $urandom;
      8:       return '0;
      default: return WORD_MAX;
    endcase
  endfunction

  function automatic logic [31:0] rand_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7);
      4, 5, 6, 7: return $urandom;
      8:          return '0;
      default:    return WORD_MAX;
    endcase
  endfunction

  // long bursts only late, they can push the time past every arrival
  function automatic logic [31:0] rand_burst();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 15);
      6, 7, 8:          return $urandom_range(0, 2000);
      default: begin
        if (words_sent < WIDE_FROM) return $urandom_range(16, 255);
        return $urandom_range(0, 1) ? $urandom : WORD_MAX;
      end
    endcase
  endfunction

  task automatic add_random_job();
    add_job(rand_arrival(), rand_priority(), rand_burst());
  endtask

  // dispatch from an empty table
  task automatic test_empty_table();
    dispatch_job();
    dispatch_job();
  endtask

  // field extremes and the not-yet-arrived pick
  task automatic test_field_extremes();
    add_job('0, WORD_MAX, '0);
    add_job(WORD_MAX, '0, 32'd5);
    add_job(32'h8000_0000, 32'h8000_0000, 32'h0000_7FFF);
    dispatch_job();
    add_job(32'd5, 32'd5, 32'd1);
    add_job(32'd3, 32'd3, 32'd1);
    dispatch_job();
    dispatch_job();
  endtask

  // equal aged priority: burst then index decide; equal earliest arrival too
  task automatic test_tie_breaks();
    add_job(32'd2, 32'd10, 32'd9);
    add_job(32'd4, 32'd12, 32'd3);
    add_job(32'd1, 32'd9, 32'd3);
    repeat (3) dispatch_job();
    add_job(32'd1000, 32'd1000, 32'd7);
    add_job(32'd1000, 32'd1005, 32'd7);
    repeat (2) dispatch_job();
  endtask

  // fill every slot, then adds that get dropped
  task automatic test_table_full();
    repeat (JOBS - live_jobs() + 2) add_random_job();
  endtask

  // mostly add batches followed by dispatches, with fills, drains and noise
  task automatic test_random_traffic();
    int unsigned kind;
    int unsigned n;
    in_t         w;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= STEADY_FROM) steady_drive = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        n = $urandom_range(1, 12);
        repeat (n) add_random_job();
        repeat ($urandom_range(1, n + 2)) dispatch_job();
      end else if (kind < 13) begin
        repeat (JOBS - live_jobs() + $urandom_range(1, 3)) add_random_job();
      end else if (kind < 16) begin
        repeat (live_jobs() + $urandom_range(0, 2)) dispatch_job();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          w.opcode       = 1'($urandom_range(0, 1));
          w.arrival      = $urandom;
          w.priority_req = $urandom;
          w.burst        = $urandom;
          send_word(w);
        end
      end
    end
  endtask

  // longest bursts at the end, after the table is drained
  task automatic test_long_bursts();
    steady_drive = 1'b1;
    repeat (live_jobs() + 1) dispatch_job();
    add_job(WORD_MAX, WORD_MAX, WORD_MAX);
    add_job('0, '0, WORD_MAX);
    add_job(32'd7, WORD_MAX, 32'd1);
    repeat (4) dispatch_job();
  endtask

  initial begin
    for (int i = 0; i < JOBS; i++) job_live[i] = 1'b0;
    sched_time = '0;
    next_tag   = JOB_IDX_W'(1);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_field_extremes();
    test_tie_breaks();
    test_table_full();
    test_random_traffic();
    test_long_bursts();

    // drain the last results
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (JOBS + 4) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
